/* sv/traffic_rate_jitter_meter_macros.svh */
// assertion macros for the traffic rate and jitter meter
`ifndef TRAFFIC_RATE_JITTER_METER_MACROS_SVH
`define TRAFFIC_RATE_JITTER_METER_MACROS_SVH

// checked only out of reset
`define TRJM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("trjm assertion failed");

// checked on every edge, reset included
`define TRJM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("trjm assertion failed");

`endif

/* sv/trjm_pkg.sv */
// types and constants of the traffic rate and jitter meter
package trjm_pkg;

  localparam int unsigned RATE_W     = 40;
  localparam int unsigned CNT_W      = 48;
  localparam int unsigned BYTE_W     = 32;
  localparam int unsigned TS_W       = 48;
  localparam int unsigned IVL_W      = 32;
  localparam int unsigned WARM_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ACC_W      = 128;
  localparam int unsigned MUL_A_W    = 52;
  localparam int unsigned CHUNK_W    = 24;
  localparam int unsigned MUL_B_W    = 96;
  localparam int unsigned PROD_W     = MUL_A_W + CHUNK_W;
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned REM_W      = 66;
  localparam int unsigned STEP_W     = 8;

  localparam logic [STEP_W-1:0]  MUL_CHUNKS = 8'd4;
  localparam logic [STEP_W-1:0]  DIV_STEPS  = 8'd128;
  localparam logic [STEP_W-1:0]  SQRT_STEPS = 8'd64;
  localparam logic [MUL_B_W-1:0] RATE_SCALE = 96'd2000000;
  localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
  localparam logic [IVL_W-1:0]   INTERVAL_RST = 32'd100000;
  localparam logic [WARM_W-1:0]  WARMUP_RST   = 8'd5;
  localparam logic [WARM_W-1:0]  SEEN_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP       = 8'd1;

  typedef enum logic [0:0] {
    OP_PACKET = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IDIV,
    ST_IFIN,
    ST_AMUL,
    ST_ADIV,
    ST_AFIN,
    ST_JRD,
    ST_JLD,
    ST_JSQ,
    ST_JACC,
    ST_NMUL,
    ST_NSAVE,
    ST_SMUL,
    ST_SUB,
    ST_SQRT,
    ST_JDLD,
    ST_JDIV,
    ST_JFIN,
    ST_FIN
  } state_e;

endpackage

/* sv/trjm_if.sv */
// channel interfaces of the traffic rate and jitter meter
interface trjm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [trjm_pkg::BYTE_W-1:0] byte_count;
  logic [trjm_pkg::TS_W-1:0]   timestamp_us;
  modport source (output valid, opcode, byte_count, timestamp_us, input ready);
  modport sink (input valid, opcode, byte_count, timestamp_us, output ready);
endinterface

interface trjm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        stats_valid;
  logic                        new_sample;
  logic [trjm_pkg::RATE_W-1:0] instant_rate;
  logic [trjm_pkg::RATE_W-1:0] max_rate;
  logic [trjm_pkg::RATE_W-1:0] min_rate;
  logic [trjm_pkg::RATE_W-1:0] avg_rate;
  logic [trjm_pkg::RATE_W-1:0] jitter;
  logic [trjm_pkg::CNT_W-1:0]  total_bytes;
  modport source (output valid, stats_valid, new_sample, instant_rate, max_rate, min_rate,
                  avg_rate, jitter, total_bytes, input ready);
  modport sink (input valid, stats_valid, new_sample, instant_rate, max_rate, min_rate,
                avg_rate, jitter, total_bytes, output ready);
endinterface

interface trjm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [trjm_pkg::CFG_IDX_W-1:0]  index;
  logic [trjm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/traffic_rate_jitter_meter.sv */
// traffic rate and jitter meter top level
//
//   channel  dir  carries
//   cfg_i    in   register index and write data
//   pkt_i    in   opcode, byte count, timestamp
//   res_o    out  rate statistics and byte total
//
// clear, first packet and short gap: answered from idle without the datapath
// rate sample: runs the shared
// multiply step, the one-bit-per-cycle divide and root loops and the window walk
// pkt_i is ready only while idle with the result register empty
// rst_ni clears all control state at once, the window store needs no clearing
`include "traffic_rate_jitter_meter_macros.svh"

module traffic_rate_jitter_meter #(
  parameter int unsigned WINDOW_DEPTH = 100
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trjm_cfg_if.sink   cfg_i,
  trjm_in_if.sink    pkt_i,
  trjm_out_if.source res_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned S1_W   = trjm_pkg::RATE_W + FILL_W;

  localparam int unsigned RW  = trjm_pkg::RATE_W;
  localparam int unsigned CW  = trjm_pkg::CNT_W;
  localparam int unsigned AW  = trjm_pkg::ACC_W;
  localparam int unsigned MAW = trjm_pkg::MUL_A_W;
  localparam int unsigned MBW = trjm_pkg::MUL_B_W;
  localparam int unsigned KW  = trjm_pkg::CHUNK_W;
  localparam int unsigned QW  = trjm_pkg::ROOT_W;
  localparam int unsigned XW  = trjm_pkg::REM_W;
  localparam int unsigned SW  = trjm_pkg::STEP_W;

  trjm_pkg::state_e state_q, state_d;

  logic [SW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  acc_q, acc_d;
  logic [MAW-1:0] mul_a_q, mul_a_d;
  logic [MBW-1:0] mul_b_q, mul_b_d;
  logic [CW-1:0]  div_d_q, div_d_d;
  logic [XW-1:0]  rem_q, rem_d;
  logic [QW-1:0]  quo_q, quo_d;
  logic           sat_q, sat_d;
  logic [S1_W-1:0] s1_q, s1_d;
  logic [AW-1:0]  s2_q, s2_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [RW-1:0]  rd_data_q;
  logic [RW-1:0]  win_mem [WINDOW_DEPTH];
  logic           win_we;

  logic [trjm_pkg::IVL_W-1:0]  min_ivl_q, min_ivl_d;
  logic [trjm_pkg::WARM_W-1:0] warmup_q, warmup_d;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CW-1:0]     total_q, total_d;
  logic [CW-1:0]     pending_q, pending_d;
  logic [CW-1:0]     last_q, last_d;
  logic [CW-1:0]     start_q, start_d;
  logic [CW-1:0]     now_q, now_d;
  logic [CW-1:0]     dt_q, dt_d;
  logic              awaiting_q, awaiting_d;
  logic [RW-1:0]     peak_q, peak_d;
  logic [RW-1:0]     floor_q, floor_d;
  logic              floor_set_q, floor_set_d;
  logic [RW-1:0]     mean_q, mean_d;
  logic [RW-1:0]     jit_q, jit_d;
  logic [RW-1:0]     inst_q, inst_d;
  logic [trjm_pkg::WARM_W-1:0] seen_q, seen_d;

  logic          out_valid_q, out_valid_d;
  logic          o_stats_q, o_stats_d;
  logic          o_new_q, o_new_d;
  logic [RW-1:0] o_inst_q, o_inst_d;
  logic [RW-1:0] o_max_q, o_max_d;
  logic [RW-1:0] o_min_q, o_min_d;
  logic [RW-1:0] o_avg_q, o_avg_d;
  logic [RW-1:0] o_jit_q, o_jit_d;
  logic [CW-1:0] o_total_q, o_total_d;

  logic          pkt_fire, cfg_fire, res_fire, is_clear;
  logic [CW:0]   total_sum, pending_sum;
  logic [CW-1:0] total_new, pending_new, dt_in, span;
  logic [trjm_pkg::IVL_W-1:0] interval;
  logic          dt_short, span_zero, last_step, last_entry, few_samples;
  logic [trjm_pkg::PROD_W-1:0] prod;
  logic [AW-1:0] acc_mul;
  logic [CW:0]   div_sh, div_sub;
  logic          div_ge;
  logic [XW-1:0] sq_sh, sq_trial;
  logic          sq_ge;
  logic [RW-1:0] div_res;
  logic [AW-1:0] s2_add;
  logic [trjm_pkg::WARM_W-1:0] seen_inc;

  assign pkt_fire = pkt_i.valid & pkt_i.ready;
  assign cfg_fire = cfg_i.valid & cfg_i.ready;
  assign res_fire = res_o.valid & res_o.ready;
  assign is_clear = (pkt_i.opcode == trjm_pkg::OP_CLEAR);

  assign pkt_i.ready = (state_q == trjm_pkg::ST_IDLE) && !out_valid_q;
  assign cfg_i.ready = 1'b1;

  assign total_sum   = {1'b0, total_q} + (CW + 1)'(pkt_i.byte_count);
  assign pending_sum = {1'b0, pending_q} + (CW + 1)'(pkt_i.byte_count);
  assign total_new   = total_sum[CW] ? '1 : total_sum[CW-1:0];
  assign pending_new = pending_sum[CW] ? '1 : pending_sum[CW-1:0];
  assign interval    = (min_ivl_q == '0) ? trjm_pkg::IVL_W'(1) : min_ivl_q;
  assign dt_in       = pkt_i.timestamp_us - last_q;
  assign dt_short    = dt_in < CW'(interval);
  assign span        = now_q - start_q;
  assign span_zero   = (span == '0);
  assign last_step   = (cnt_q == SW'(1));
  assign last_entry  = (FILL_W'(idx_q) == fill_q - FILL_W'(1));
  assign few_samples = (fill_q < FILL_W'(2));

  // shared multiply step, most significant chunk first
  assign prod    = mul_a_q * mul_b_q[MBW-1 -: KW];
  assign acc_mul = {acc_q[AW-KW-1:0], {KW{1'b0}}} + AW'(prod);

  // restoring divide step
  assign div_sh  = {rem_q[CW-1:0], acc_q[AW-1]};
  assign div_ge  = div_sh >= {1'b0, div_d_q};
  assign div_sub = div_sh - {1'b0, div_d_q};
  assign div_res = (sat_q || (quo_q[QW-1:RW] != '0)) ? trjm_pkg::RATE_MAX : quo_q[RW-1:0];

  // square root step, two radicand bits per cycle
  assign sq_sh    = {rem_q[XW-3:0], acc_q[AW-1 -: 2]};
  assign sq_trial = {quo_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  assign s2_add   = s2_q + acc_q;
  assign seen_inc = (seen_q < trjm_pkg::SEEN_MAX) ? seen_q + trjm_pkg::WARM_W'(1) : seen_q;

  assign win_we = (state_q == trjm_pkg::ST_IFIN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trjm_pkg::ST_IDLE: begin
        if (pkt_fire && !is_clear && !awaiting_q && !dt_short) state_d = trjm_pkg::ST_IMUL;
      end
      trjm_pkg::ST_IMUL:  if (last_step) state_d = trjm_pkg::ST_IDIV;
      trjm_pkg::ST_IDIV:  if (last_step) state_d = trjm_pkg::ST_IFIN;
      trjm_pkg::ST_IFIN:  state_d = span_zero ? trjm_pkg::ST_AFIN : trjm_pkg::ST_AMUL;
      trjm_pkg::ST_AMUL:  if (last_step) state_d = trjm_pkg::ST_ADIV;
      trjm_pkg::ST_ADIV:  if (last_step) state_d = trjm_pkg::ST_AFIN;
      trjm_pkg::ST_AFIN:  state_d = few_samples ? trjm_pkg::ST_FIN : trjm_pkg::ST_JRD;
      trjm_pkg::ST_JRD:   state_d = trjm_pkg::ST_JLD;
      trjm_pkg::ST_JLD:   state_d = trjm_pkg::ST_JSQ;
      trjm_pkg::ST_JSQ:   if (last_step) state_d = trjm_pkg::ST_JACC;
      trjm_pkg::ST_JACC:  state_d = last_entry ? trjm_pkg::ST_NMUL : trjm_pkg::ST_JRD;
      trjm_pkg::ST_NMUL:  if (last_step) state_d = trjm_pkg::ST_NSAVE;
      trjm_pkg::ST_NSAVE: state_d = trjm_pkg::ST_SMUL;
      trjm_pkg::ST_SMUL:  if (last_step) state_d = trjm_pkg::ST_SUB;
      trjm_pkg::ST_SUB:   state_d = trjm_pkg::ST_SQRT;
      trjm_pkg::ST_SQRT:  if (last_step) state_d = trjm_pkg::ST_JDLD;
      trjm_pkg::ST_JDLD:  state_d = trjm_pkg::ST_JDIV;
      trjm_pkg::ST_JDIV:  if (last_step) state_d = trjm_pkg::ST_JFIN;
      trjm_pkg::ST_JFIN:  state_d = trjm_pkg::ST_FIN;
      trjm_pkg::ST_FIN:   state_d = trjm_pkg::ST_IDLE;
      default:            state_d = trjm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;  acc_d = acc_q;  mul_a_d = mul_a_q;  mul_b_d = mul_b_q;
    div_d_d = div_d_q;  rem_d = rem_q;  quo_d = quo_q;  sat_d = sat_q;
    s1_d = s1_q;  s2_d = s2_q;  idx_d = idx_q;
    min_ivl_d = min_ivl_q;  warmup_d = warmup_q;
    fill_d = fill_q;  head_d = head_q;  total_d = total_q;  pending_d = pending_q;
    last_d = last_q;  start_d = start_q;  now_d = now_q;  dt_d = dt_q;
    awaiting_d = awaiting_q;  peak_d = peak_q;  floor_d = floor_q;
    floor_set_d = floor_set_q;  mean_d = mean_q;  jit_d = jit_q;  inst_d = inst_q;
    seen_d = seen_q;
    out_valid_d = out_valid_q & ~res_fire;
    o_stats_d = o_stats_q;  o_new_d = o_new_q;  o_inst_d = o_inst_q;  o_max_d = o_max_q;
    o_min_d = o_min_q;  o_avg_d = o_avg_q;  o_jit_d = o_jit_q;  o_total_d = o_total_q;

    if (cfg_fire) begin
      if (cfg_i.index == trjm_pkg::REG_MIN_INTERVAL) min_ivl_d = cfg_i.data;
      else if (cfg_i.index == trjm_pkg::REG_WARMUP) warmup_d = cfg_i.data[trjm_pkg::WARM_W-1:0];
    end

    unique case (state_q)
      trjm_pkg::ST_IDLE: begin
        if (pkt_fire) begin
          if (is_clear) begin
            fill_d = '0;  head_d = '0;  total_d = '0;  pending_d = '0;  last_d = '0;
            start_d = '0;  awaiting_d = 1'b1;  peak_d = '0;  floor_d = '0;
            floor_set_d = 1'b0;  mean_d = '0;  jit_d = '0;  inst_d = '0;  seen_d = '0;
            out_valid_d = 1'b1;  o_stats_d = 1'b0;  o_new_d = 1'b0;  o_inst_d = '0;
            o_max_d = '0;  o_min_d = '0;  o_avg_d = '0;  o_jit_d = '0;  o_total_d = '0;
          end else begin
            total_d   = total_new;
            pending_d = pending_new;
            if (awaiting_q) begin
              awaiting_d = 1'b0;  last_d = pkt_i.timestamp_us;  start_d = pkt_i.timestamp_us;
              out_valid_d = 1'b1;  o_stats_d = 1'b0;  o_new_d = 1'b0;  o_inst_d = '0;
              o_max_d = '0;  o_min_d = '0;  o_avg_d = '0;  o_jit_d = '0;  o_total_d = '0;
            end else if (dt_short) begin
              out_valid_d = 1'b1;  o_stats_d = 1'b1;  o_new_d = 1'b0;  o_inst_d = inst_q;
              o_max_d = peak_q;  o_min_d = floor_set_q ? floor_q : '0;  o_avg_d = mean_q;
              o_jit_d = jit_q;  o_total_d = total_new;
            end else begin
              now_d = pkt_i.timestamp_us;  dt_d = dt_in;
              mul_a_d = MAW'(pending_new);  mul_b_d = trjm_pkg::RATE_SCALE;
              acc_d = '0;  cnt_d = trjm_pkg::MUL_CHUNKS;
            end
          end
        end
      end
      trjm_pkg::ST_IMUL, trjm_pkg::ST_AMUL: begin
        acc_d = acc_mul;  mul_b_d = mul_b_q << KW;  cnt_d = cnt_q - SW'(1);
        if (last_step) begin
          cnt_d = trjm_pkg::DIV_STEPS;  rem_d = '0;  quo_d = '0;  sat_d = 1'b0;
          div_d_d = (state_q == trjm_pkg::ST_IMUL) ? dt_q : span;
        end
      end
      trjm_pkg::ST_IDIV, trjm_pkg::ST_ADIV, trjm_pkg::ST_JDIV: begin
        rem_d = XW'(div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0]);
        quo_d = {quo_q[QW-2:0], div_ge};
        sat_d = sat_q | (quo_q[QW-1:RW] != '0);
        acc_d = acc_q << 1;
        cnt_d = cnt_q - SW'(1);
      end
      trjm_pkg::ST_IFIN: begin
        inst_d = div_res;
        if (div_res > peak_q) peak_d = div_res;
        seen_d = seen_inc;
        if ((seen_inc > warmup_q) && (!floor_set_q || (div_res < floor_q))) begin
          floor_d = div_res;  floor_set_d = 1'b1;
        end
        head_d = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        if (fill_q != FILL_W'(WINDOW_DEPTH)) fill_d = fill_q + FILL_W'(1);
        mul_a_d = MAW'(total_q);  mul_b_d = trjm_pkg::RATE_SCALE;
        acc_d = '0;  cnt_d = trjm_pkg::MUL_CHUNKS;
      end
      trjm_pkg::ST_AFIN: begin
        mean_d = span_zero ? '0 : div_res;
        if (few_samples) jit_d = '0;
        idx_d = '0;  s1_d = '0;  s2_d = '0;
      end
      trjm_pkg::ST_JRD: begin
      end
      trjm_pkg::ST_JLD: begin
        mul_a_d = MAW'(rd_data_q);  mul_b_d = MBW'(rd_data_q);
        acc_d = '0;  cnt_d = trjm_pkg::MUL_CHUNKS;
        s1_d = s1_q + S1_W'(rd_data_q);
      end
      trjm_pkg::ST_JSQ, trjm_pkg::ST_NMUL, trjm_pkg::ST_SMUL: begin
        acc_d = acc_mul;  mul_b_d = mul_b_q << KW;  cnt_d = cnt_q - SW'(1);
      end
      trjm_pkg::ST_JACC: begin
        s2_d = s2_add;
        if (last_entry) begin
          mul_a_d = MAW'(fill_q);  mul_b_d = s2_add[MBW-1:0];
          acc_d = '0;  cnt_d = trjm_pkg::MUL_CHUNKS;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      trjm_pkg::ST_NSAVE: begin
        s2_d = acc_q;
        mul_a_d = MAW'(s1_q);  mul_b_d = MBW'(s1_q);
        acc_d = '0;  cnt_d = trjm_pkg::MUL_CHUNKS;
      end
      trjm_pkg::ST_SUB: begin
        acc_d = s2_q - acc_q;
        cnt_d = trjm_pkg::SQRT_STEPS;  rem_d = '0;  quo_d = '0;
      end
      trjm_pkg::ST_SQRT: begin
        rem_d = sq_ge ? sq_sh - sq_trial : sq_sh;
        quo_d = {quo_q[QW-2:0], sq_ge};
        acc_d = acc_q << 2;
        cnt_d = cnt_q - SW'(1);
      end
      trjm_pkg::ST_JDLD: begin
        acc_d = AW'(quo_q);  div_d_d = CW'(fill_q);
        cnt_d = trjm_pkg::DIV_STEPS;  rem_d = '0;  quo_d = '0;  sat_d = 1'b0;
      end
      trjm_pkg::ST_JFIN: begin
        jit_d = div_res;
      end
      trjm_pkg::ST_FIN: begin
        pending_d = '0;  last_d = now_q;
        out_valid_d = 1'b1;  o_stats_d = 1'b1;  o_new_d = 1'b1;  o_inst_d = inst_q;
        o_max_d = peak_q;  o_min_d = floor_set_q ? floor_q : '0;  o_avg_d = mean_q;
        o_jit_d = jit_q;  o_total_d = total_q;
      end
      default: begin
      end
    endcase
  end

  // window store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[head_q] <= div_res;
    rd_data_q <= win_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trjm_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      min_ivl_q   <= trjm_pkg::INTERVAL_RST;
      warmup_q    <= trjm_pkg::WARMUP_RST;
      fill_q      <= '0;
      head_q      <= '0;
      total_q     <= '0;
      pending_q   <= '0;
      last_q      <= '0;
      start_q     <= '0;
      awaiting_q  <= 1'b1;
      peak_q      <= '0;
      floor_q     <= '0;
      floor_set_q <= 1'b0;
      mean_q      <= '0;
      jit_q       <= '0;
      inst_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      min_ivl_q   <= min_ivl_d;
      warmup_q    <= warmup_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      total_q     <= total_d;
      pending_q   <= pending_d;
      last_q      <= last_d;
      start_q     <= start_d;
      awaiting_q  <= awaiting_d;
      peak_q      <= peak_d;
      floor_q     <= floor_d;
      floor_set_q <= floor_set_d;
      mean_q      <= mean_d;
      jit_q       <= jit_d;
      inst_q      <= inst_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    div_d_q   <= div_d_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    sat_q     <= sat_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    now_q     <= now_d;
    dt_q      <= dt_d;
    o_stats_q <= o_stats_d;
    o_new_q   <= o_new_d;
    o_inst_q  <= o_inst_d;
    o_max_q   <= o_max_d;
    o_min_q   <= o_min_d;
    o_avg_q   <= o_avg_d;
    o_jit_q   <= o_jit_d;
    o_total_q <= o_total_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.stats_valid  = o_stats_q;
  assign res_o.new_sample   = o_new_q;
  assign res_o.instant_rate = o_inst_q;
  assign res_o.max_rate     = o_max_q;
  assign res_o.min_rate     = o_min_q;
  assign res_o.avg_rate     = o_avg_q;
  assign res_o.jitter       = o_jit_q;
  assign res_o.total_bytes  = o_total_q;

  `TRJM_ASSERT(a_busy_no_result, (state_q != trjm_pkg::ST_IDLE) |-> !out_valid_q)
  `TRJM_ASSERT(a_take_then_busy, pkt_fire |=> !pkt_i.ready)
  `TRJM_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(WINDOW_DEPTH))

endmodule
